@@ rtl/core/avp_pkg.sv @@
// Shared types, constants and codes for the 2x2 average pooling stream block.
`default_nettype none
package avp_pkg;

	localparam int MAX_IN_WIDTH  = 64;
	localparam int MAX_IN_HEIGHT = 64;
	localparam int MAX_CHANNELS  = 16;
	localparam int LINE_DEPTH    = MAX_IN_WIDTH / 2;

	localparam int SAMPLE_W  = 8;
	localparam int AVG_W     = 6;
	localparam int SLOT_W    = $clog2(LINE_DEPTH);
	localparam int COL_W     = $clog2(MAX_IN_WIDTH);
	localparam int ROW_W     = $clog2(MAX_IN_HEIGHT);
	localparam int CH_W      = $clog2(MAX_CHANNELS);
	localparam int OWID_W    = 6;
	localparam int OHGT_W    = 6;
	localparam int CHCNT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_EMIT  = 1'b1;

	typedef struct packed {
		logic                op;
		logic [SLOT_W-1:0]   slot;
		logic [SAMPLE_W-1:0] pair;
		logic                last;
	} cmd_t;

	typedef struct packed {
		logic cmd_pop;
		logic emit_take;
		logic res_push;
		logic res_at_cap;
	} back_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/avp_front.sv @@
// Front end: configuration registers, raster counters and horizontal pair forming.
`default_nettype none
module avp_front
	import avp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic                 accept,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic                      cmd_push,
	output cmd_t                      cmd
);

	logic [OWID_W-1:0]   out_width_q;
	logic [OHGT_W-1:0]   out_height_q;
	logic [CHCNT_W-1:0]  channel_count_q;
	logic [SAMPLE_W-1:0] held_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CH_W-1:0]     ch_q;

	logic [OWID_W-1:0]   w_lim;
	logic [OHGT_W-1:0]   h_lim;
	logic [CHCNT_W-1:0]  chans;
	logic [COL_W:0]      w_in;
	logic [ROW_W:0]      h_in;
	logic                last_col, last_row, last_ch;

	always_comb begin
		if (out_width_q == '0) begin
			w_lim = OWID_W'(1);
		end else if (out_width_q > OWID_W'(MAX_IN_WIDTH / 2)) begin
			w_lim = OWID_W'(MAX_IN_WIDTH / 2);
		end else begin
			w_lim = out_width_q;
		end
		if (out_height_q == '0) begin
			h_lim = OHGT_W'(1);
		end else if (out_height_q > OHGT_W'(MAX_IN_HEIGHT / 2)) begin
			h_lim = OHGT_W'(MAX_IN_HEIGHT / 2);
		end else begin
			h_lim = out_height_q;
		end
		if (channel_count_q == '0) begin
			chans = CHCNT_W'(1);
		end else if (channel_count_q > CHCNT_W'(MAX_CHANNELS)) begin
			chans = CHCNT_W'(MAX_CHANNELS);
		end else begin
			chans = channel_count_q;
		end
	end

	assign w_in     = {w_lim, 1'b0};
	assign h_in     = {h_lim, 1'b0};
	assign last_col = ({1'b0, col_q} + (COL_W + 1)'(1)) >= w_in;
	assign last_row = ({1'b0, row_q} + (ROW_W + 1)'(1)) >= h_in;
	assign last_ch  = (CHCNT_W'(ch_q) + CHCNT_W'(1)) >= chans;

	// Only the odd column of a pair produces work for the back end.
	assign cmd_push  = accept && col_q[0];
	assign cmd.op    = row_q[0] ? OP_EMIT : OP_STORE;
	assign cmd.slot  = col_q[COL_W-1:1];
	assign cmd.pair  = held_q + sample;
	assign cmd.last  = last_col && last_row && last_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q     <= OWID_W'(32);
			out_height_q    <= OHGT_W'(32);
			channel_count_q <= CHCNT_W'(16);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OUT_WIDTH:     out_width_q     <= cfg_data[OWID_W-1:0];
				CFG_OUT_HEIGHT:    out_height_q    <= cfg_data[OHGT_W-1:0];
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			ch_q   <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				held_q <= sample;
			end
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
					ch_q  <= last_ch ? '0 : ch_q + CH_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/avp_cmd_q.sv @@
// Two-entry command queue between the front end and the back end.
`default_nettype none
module avp_cmd_q
	import avp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      din,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/avp_back.sv @@
// Back end: pair-sum line store, vertical add and the result queue.
`default_nettype none
module avp_back
	import avp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             head,
	input  wire logic        cmd_empty,
	output logic             cmd_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [AVG_W-1:0] average,
	output logic             frame_last,
	output back_stat_t       stat
);

	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);

	logic [SAMPLE_W-1:0] line_q [LINE_DEPTH];
	logic [SAMPLE_W-1:0] above_s1, pair_s1;
	logic                last_s1, valid_s1;

	logic [AVG_W-1:0]  res_avg_q  [RES_DEPTH];
	logic              res_last_q [RES_DEPTH];
	logic [RES_PW-1:0] res_wr_q, res_rd_q;
	logic [RES_PW:0]   res_cnt_q;

	logic                room, take, emit_take, res_pop, res_push;
	logic [SAMPLE_W-1:0] sum4;

	// An emit reserves a result entry while it sits in the read stage.
	assign room      = (res_cnt_q + (RES_PW + 1)'(valid_s1)) < (RES_PW + 1)'(RES_DEPTH);
	assign take      = !cmd_empty && (head.op == OP_STORE || room);
	assign emit_take = take && head.op == OP_EMIT;
	assign cmd_pop   = take;

	assign res_push = valid_s1;
	assign res_pop  = pop && !empty;
	assign sum4     = above_s1 + pair_s1;

	assign empty      = res_cnt_q == '0;
	assign average    = res_avg_q[res_rd_q];
	assign frame_last = res_last_q[res_rd_q];

	assign stat.cmd_pop    = take;
	assign stat.emit_take  = emit_take;
	assign stat.res_push   = res_push;
	assign stat.res_at_cap = res_cnt_q == (RES_PW + 1)'(RES_DEPTH);

	always_ff @(posedge clk) begin
		if (take && head.op == OP_STORE) begin
			line_q[head.slot] <= head.pair;
		end
		if (emit_take) begin
			above_s1 <= line_q[head.slot];
			pair_s1  <= head.pair;
			last_s1  <= head.last;
		end
		if (res_push) begin
			res_avg_q[res_wr_q]  <= sum4[SAMPLE_W-1:2];
			res_last_q[res_wr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			valid_s1 <= emit_take;
			if (res_push) begin
				res_wr_q <= res_wr_q + RES_PW'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + RES_PW'(1);
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + (RES_PW + 1)'(1);
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - (RES_PW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/avg_pool_2x2_stream_top.sv @@
// Top level of the streaming 2x2 stride-2 average pooling block.
`default_nettype none
// Samples are unsigned 4.4 bytes in channel, row, column raster order, one
// request per clock at most; the block sustains one sample per cycle while
// full is low. A request is taken when push is high and full is low. For
// each 2x2 window the four samples are added modulo 256 and the sum shifted
// right by two gives the 6-bit average; frame_last marks the final result
// of the last row of the last channel. A result is registered through the
// command queue, the read stage and the result queue before it shows on
// average/frame_last, and stays there until popped. The
// front end counts columns, rows and channels against the configured sizes
// (clamped into their legal ranges, zero acting as one) and forms the sum of
// each horizontal pair. A two-entry command queue decouples it from the back
// end, which keeps a 32-entry line of pair sums from the even input row,
// adds the odd row on top and drains results through a four-entry output
// queue. Configuration writes take effect on the next edge and should only
// be issued while the block is idle; the counters are not cleared by them.
module avg_pool_2x2_stream_top
	import avp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [AVG_W-1:0]          average,
	output logic                      frame_last
);

	logic       accept;
	logic       cmd_push, cmd_pop, cmd_empty, cmd_full;
	cmd_t       cmd, cmd_head;
	back_stat_t stat;

	// The input side stalls only when the command queue is full.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	avp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.sample    (sample),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	avp_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.pop    (cmd_pop),
		.head   (cmd_head),
		.empty  (cmd_empty),
		.full   (cmd_full)
	);

	avp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.average    (average),
		.frame_last (frame_last),
		.stat       (stat)
	);

	// The front end never hands a command to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

	// The back end only consumes commands that are present.
	assert property (@(posedge clk) disable iff (!arst_n) stat.cmd_pop |-> !cmd_empty)
		else $error("command popped from an empty queue");

	// The reservation in the back end keeps the result queue from overflowing.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_push |-> !stat.res_at_cap)
		else $error("result written into a full result queue");

	// Every accepted emit lands in the result queue in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) stat.emit_take |=> stat.res_push)
		else $error("emit command lost in the read stage");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the streaming 2x2 stride-2 average pooling block.
module tb_top;
	import avp_pkg::*;

	// Each pooled result as the block should report it.
	typedef struct packed {
		logic [AVG_W-1:0] avg;
		logic             last;
	} pool_res_t;

	// Hand-picked corner samples. The first twenty form five 1x1x1 frames
	// (all ones, all zeros, a sum of exactly 255, a sum that wraps to zero and
	// a mixed pattern). The last eight form one two-channel frame, so the
	// frame_last flag is seen both low and high.
	localparam logic [SAMPLE_W-1:0] CORNER [0:27] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h00, 8'h00, 8'h00, 8'h00,
		8'h40, 8'h40, 8'h40, 8'h3F,
		8'h80, 8'h80, 8'h80, 8'h80,
		8'h0F, 8'hF0, 8'h55, 8'hAA,
		8'h01, 8'h02, 8'h04, 8'h08,
		8'h10, 8'h20, 8'h40, 8'h80
	};

	localparam int RANDOM_ITEMS = 1900;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;
	logic                 push       = 1'b0;
	logic [SAMPLE_W-1:0]  sample     = '0;
	logic                 pop        = 1'b0;
	logic                 full;
	logic                 empty;
	logic [AVG_W-1:0]     average;
	logic                 frame_last;

	// Samples waiting to be offered, and the pooled results still owed by the
	// block, oldest first.
	logic [SAMPLE_W-1:0] sample_q [$];
	pool_res_t           pooled_q [$];

	int unsigned queued_cnt = 0;
	int unsigned taken_cnt  = 0;
	int unsigned err_cnt    = 0;
	int unsigned cyc        = 0;

	// Our own copy of the block's registers and counters. The registers hold
	// the raw written values; clamping happens when they are used, just as in
	// the block.
	logic [OWID_W-1:0]   shape_w  = 6'd32;
	logic [OHGT_W-1:0]   shape_h  = 6'd32;
	logic [CHCNT_W-1:0]  shape_ch = 5'd16;
	logic [SAMPLE_W-1:0] pair_line [LINE_DEPTH];
	logic [SAMPLE_W-1:0] held_byte = '0;
	int                  col_pos   = 0;
	int                  row_pos   = 0;
	int                  chan_pos  = 0;

	avg_pool_2x2_stream_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.average   (average),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Free-running cycle count. While the steady window is open neither side
	// inserts any gap, so the block also sees long bursts at full rate on both
	// ends.
	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	wire steady = (cyc % 4000) >= 3000;

	function automatic int clamp_dim(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advances our copy of the block by one accepted sample. An even column
	// only holds the sample. An odd column forms the horizontal pair sum,
	// which an even row parks in the line and an odd row adds to the parked
	// sum of the same column pair to give one average.
	function automatic void predict_pool(input logic [SAMPLE_W-1:0] s);
		int                  w_in;
		int                  h_in;
		int                  chans;
		bit                  last_col;
		bit                  last_row;
		bit                  last_ch;
		logic [SAMPLE_W-1:0] pair;
		logic [SAMPLE_W-1:0] sum4;
		pool_res_t           r;

		w_in     = 2 * clamp_dim(shape_w, 1, LINE_DEPTH);
		h_in     = 2 * clamp_dim(shape_h, 1, MAX_IN_HEIGHT / 2);
		chans    = clamp_dim(shape_ch, 1, MAX_CHANNELS);
		last_col = col_pos + 1 >= w_in;
		last_row = row_pos + 1 >= h_in;
		last_ch  = chan_pos + 1 >= chans;
		taken_cnt++;

		if (col_pos % 2 == 0) begin
			held_byte = s;
		end else begin
			pair = held_byte + s;
			if (row_pos % 2 == 0) begin
				pair_line[col_pos / 2] = pair;
			end else begin
				sum4   = pair_line[col_pos / 2] + pair;
				r.avg  = sum4[SAMPLE_W-1:2];
				r.last = last_col && last_row && last_ch;
				pooled_q.push_back(r);
			end
		end

		// A counter at or past a freshly lowered limit wraps on this advance.
		if (last_col) begin
			col_pos = 0;
			if (last_row) begin
				row_pos  = 0;
				chan_pos = last_ch ? 0 : (chan_pos + 1) & 15;
			end else begin
				row_pos = (row_pos + 1) & 63;
			end
		end else begin
			col_pos = (col_pos + 1) & 63;
		end
	endfunction

	// Sample driver. A request stays up until the block takes it; between
	// requests the driver idles at random unless the steady window is open.
	always @(posedge clk) begin : feed
		bit gap;
		gap = !steady && ($urandom_range(0, 99) < 26);
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predict_pool(sample);
			if (!push || !full) begin
				if (sample_q.size() != 0 && !gap) begin
					push   <= 1'b1;
					sample <= sample_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every popped result is checked field by field against
	// the oldest pooled result still owed; pop is dropped at random to stall
	// the output queue.
	always @(posedge clk) begin : drain
		pool_res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pooled_q.size() == 0) begin
					$display("%0t: result with none expected: average %0d frame_last %0b",
						$time, average, frame_last);
					err_cnt++;
				end else begin
					want = pooled_q.pop_front();
					if (average !== want.avg) begin
						$display("%0t: average expected %0d got %0d",
							$time, want.avg, average);
						err_cnt++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0b got %0b",
							$time, want.last, frame_last);
						err_cnt++;
					end
				end
			end
			pop <= steady || ($urandom_range(0, 99) >= 26);
		end
	end

	function automatic logic [OWID_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'($urandom_range(33, 63));
			2: return 6'd32;
			default: return 6'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic add_sample(input logic [SAMPLE_W-1:0] s);
		sample_q.push_back(s);
		queued_cnt++;
	endtask

	// Waits until every queued sample has been taken and every owed result has
	// come back, then lets the block finish any sample that makes no result.
	task automatic wait_idle();
		while (taken_cnt != queued_cnt || pooled_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_OUT_WIDTH: shape_w = val;
			CFG_OUT_HEIGHT: shape_h = val;
			CFG_CHANNEL_COUNT: shape_ch = val[CHCNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Registers are only rewritten once the block has gone quiet.
	task automatic set_shape(input logic [OWID_W-1:0] ow, input logic [OHGT_W-1:0] oh,
			input logic [CHCNT_W-1:0] ch);
		wait_idle();
		write_reg(CFG_OUT_WIDTH, ow);
		write_reg(CFG_OUT_HEIGHT, oh);
		write_reg(CFG_CHANNEL_COUNT, CFG_DAT_W'(ch));
	endtask

	initial begin : stimulus
		logic [OWID_W-1:0]  ow;
		logic [OHGT_W-1:0]  oh;
		logic [CHCNT_W-1:0] ch;
		int                 frame;
		int                 n;
		int                 random_cnt;
		bit                 heavy;

		foreach (pair_line[i])
			pair_line[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Zero in every register acts as one: each frame is a single 2x2 block.
		set_shape(6'd0, 6'd0, 5'd0);
		for (int i = 0; i < 20; i++)
			add_sample(CORNER[i]);
		set_shape(6'd1, 6'd1, 5'd2);
		for (int i = 20; i < 28; i++)
			add_sample(CORNER[i]);

		// A full-width frame writes every entry of the line store, so no later
		// sequence, even one broken off mid-frame, can read an unwritten entry.
		// Next come the tallest channel (oversized height saturating) and the
		// most channels (oversized count saturating).
		random_cnt = 0;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: set_shape(6'd32, 6'd1, 5'd1);
				1: set_shape(6'd1, 6'd63, 5'd1);
				default: set_shape(6'd1, 6'd1, 5'd31);
			endcase
			n = (k == 2) ? 64 : 128;
			repeat (n) add_sample(SAMPLE_W'($urandom_range(0, 255)));
			random_cnt += n;
		end

		// Random shapes. Most runs are whole frames (once or twice over); the
		// rest stop mid-frame, so the next shape starts from odd counters.
		while (random_cnt < RANDOM_ITEMS) begin
			ow = pick_dim();
			oh = pick_dim();
			case ($urandom_range(0, 9))
				0: ch = 5'd0;
				1: ch = 5'($urandom_range(17, 31));
				2: ch = 5'd16;
				default: ch = 5'($urandom_range(1, 3));
			endcase
			set_shape(ow, oh, ch);
			frame = 4 * clamp_dim(ow, 1, LINE_DEPTH) * clamp_dim(oh, 1, MAX_IN_HEIGHT / 2)
				* clamp_dim(ch, 1, MAX_CHANNELS);
			if (frame <= 512 && $urandom_range(0, 3) != 0)
				n = frame * $urandom_range(1, 2);
			else
				n = $urandom_range(6, 160);
			// Some runs use only large samples so the sums wrap and the top
			// averages show up often.
			heavy = ($urandom_range(0, 4) == 0);
			repeat (n)
				add_sample(heavy ? SAMPLE_W'($urandom_range(192, 255))
					: SAMPLE_W'($urandom_range(0, 255)));
			random_cnt += n;
		end

		wait_idle();
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
